/* src/lpd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package lpd_pkg;

  localparam int MAX_FRAME_BYTES_DEF = 256;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int AES_ROUNDS = 10;
  localparam int RND_W = $clog2(AES_ROUNDS + 1);
  localparam int CFG_INDEX_W = 3;
  localparam logic [7:0] OPT_MASK = 8'h0f;
  localparam logic [7:0] HDR_FIXED = 8'd9;
  localparam logic [7:0] HDR_WITH_MIC = 8'd13;
  localparam logic [7:0] MIC_BYTES = 8'd4;
  localparam logic [7:0] ABLK_TAG = 8'h01;
  localparam logic [7:0] RCON_FIRST = 8'h01;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_SUMMARY = 1'b1
  } record_kind_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_APP_KEY_HIGH   = 3'd0,
    CFG_APP_KEY_LOW    = 3'd1,
    CFG_NET_KEY_HIGH   = 3'd2,
    CFG_NET_KEY_LOW    = 3'd3,
    CFG_LINK_DIRECTION = 3'd4
  } cfg_index_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_CRYPT,
    BK_LOADED
  } back_state_t;

  typedef logic [0:15][7:0] blk_t;

  typedef struct packed {
    record_kind_t kind;
    logic         fresh;
    logic         blk_start;
    logic         final_part;
    logic [3:0]   idx;
    logic [7:0]   blk_count;
    logic [7:0]   data;
    logic [31:0]  addr;
    logic [15:0]  fcnt;
    logic [7:0]   port;
    logic         status;
  } lpd_entry_t;

  typedef struct packed {
    logic [127:0] app_key;
    logic [127:0] net_key;
    logic         dir;
  } lpd_keys_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic blk_t aes_round(input blk_t s, input blk_t rk, input logic last);
    blk_t t;
    logic [7:0] a0, a1, a2, a3, all;
    int i;
    int c;
    for (i = 0; i < 16; i++) begin
      t[i] = SBOX[s[(i & 3) + 4 * (((i >> 2) + (i & 3)) & 3)]];
    end
    if (!last) begin
      for (c = 0; c < 4; c++) begin
        a0 = t[4*c];
        a1 = t[4*c+1];
        a2 = t[4*c+2];
        a3 = t[4*c+3];
        all = a0 ^ a1 ^ a2 ^ a3;
        t[4*c]   = a0 ^ all ^ xtime(a0 ^ a1);
        t[4*c+1] = a1 ^ all ^ xtime(a1 ^ a2);
        t[4*c+2] = a2 ^ all ^ xtime(a2 ^ a3);
        t[4*c+3] = a3 ^ all ^ xtime(a3 ^ a0);
      end
    end
    return t ^ rk;
  endfunction

  function automatic blk_t next_key(input blk_t k, input logic [7:0] rc);
    blk_t n;
    int i;
    n[0] = k[0] ^ SBOX[k[13]] ^ rc;
    n[1] = k[1] ^ SBOX[k[14]];
    n[2] = k[2] ^ SBOX[k[15]];
    n[3] = k[3] ^ SBOX[k[12]];
    for (i = 4; i < 16; i++) begin
      n[i] = k[i] ^ n[i-4];
    end
    return n;
  endfunction

endpackage
`default_nettype wire

/* src/lorawan_payload_decrypt_top.sv */
// LoRaWAN FRMPayload decryptor. Takes one PHYPayload byte per beat and
// returns the decrypted FRMPayload bytes, then one summary beat per frame
// with DevAddr, FCnt, FPort, the count of bytes sent and a short-frame flag.
// Header bytes and payload bytes inside a block pass at one beat per cycle
// while the queue has room and the output is not stalled. The first byte of
// each 16-byte payload block waits for its keystream from a single AES-128
// round unit (load, ten rounds, hand-over); a four-entry queue between parser
// and decryptor keeps input flowing meanwhile. The user must write keys and
// direction over the cfg port only while idle; the block does not enforce it.
`timescale 1ns / 1ps
`default_nettype none
module lorawan_payload_decrypt_top #(
  parameter int MAX_FRAME_BYTES = lpd_pkg::MAX_FRAME_BYTES_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [15:0]                    s_tdata,   // frame_byte, frame_length
  input  wire logic                           s_tuser,   // frame_start
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // plain_byte, device_address, frame_counter, port_number, payload_count,
  // frame_status, zero fill
  output logic [79:0]                         m_tdata,
  output logic                                m_tuser,   // record_kind
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [lpd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [63:0]                    cfg_data
);
  import lpd_pkg::*;

  lpd_keys_t  keys;
  lpd_entry_t wr_entry, head;
  logic       push, full, pop, head_valid;
  logic       o_kind, o_status;
  logic [7:0] o_plain, o_port, o_count;
  logic [31:0] o_addr;
  logic [15:0] o_fcnt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      keys <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_APP_KEY_HIGH:   keys.app_key[127:64] <= cfg_data;
        CFG_APP_KEY_LOW:    keys.app_key[63:0]   <= cfg_data;
        CFG_NET_KEY_HIGH:   keys.net_key[127:64] <= cfg_data;
        CFG_NET_KEY_LOW:    keys.net_key[63:0]   <= cfg_data;
        CFG_LINK_DIRECTION: keys.dir             <= cfg_data[0];
        default: ;
      endcase
    end
  end

  lpd_front #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_byte   (s_tdata[7:0]),
    .in_start  (s_tuser),
    .in_length (s_tdata[15:8]),
    .push      (push),
    .entry     (wr_entry),
    .full      (full)
  );

  lpd_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .wr_entry   (wr_entry),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  lpd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .keys       (keys),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_kind   (o_kind),
    .out_plain  (o_plain),
    .out_addr   (o_addr),
    .out_fcnt   (o_fcnt),
    .out_port   (o_port),
    .out_count  (o_count),
    .out_status (o_status)
  );

  assign m_tuser = o_kind;
  assign m_tdata = {7'd0, o_status, o_count, o_port, o_fcnt, o_addr, o_plain};

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");
  a_summary_plain: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[7:0] == 8'd0)
    else $error("summary beat carries payload byte");
  a_payload_hdr: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[72:8] == '0)
    else $error("payload beat carries header fields");
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("queue written while full");

endmodule
`default_nettype wire

/* src/lpd_front.sv */
`timescale 1ns / 1ps
`default_nettype none
module lpd_front #(
  parameter int MAX_FRAME_BYTES = lpd_pkg::MAX_FRAME_BYTES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [7:0]         in_byte,
  input  wire logic               in_start,
  input  wire logic [7:0]         in_length,
  output logic                    push,
  output lpd_pkg::lpd_entry_t     entry,
  input  wire logic               full
);
  import lpd_pkg::*;

  localparam logic [8:0] MaxLen = 9'(MAX_FRAME_BYTES);

  logic [7:0]  pos, len, port;
  logic [31:0] addr;
  logic [15:0] fcnt;
  logic [3:0]  opt;
  logic        fresh;

  logic [7:0]  pos_next, len_next, port_next, p, off, plen, clamp;
  logic [31:0] addr_next;
  logic [15:0] fcnt_next;
  logic [3:0]  opt_next;
  logic        fresh_eff, active, is_hdr, in_pay, last, accept;

  assign in_ready = !full;
  assign accept = in_valid && in_ready;

  always_comb begin
    clamp     = ({1'b0, in_length} > MaxLen) ? MaxLen[7:0] : in_length;
    len_next  = in_start ? clamp : len;
    p         = in_start ? 8'd0 : pos;
    addr_next = in_start ? 32'd0 : addr;
    fcnt_next = in_start ? 16'd0 : fcnt;
    opt_next  = in_start ? 4'd0 : opt;
    port_next = in_start ? 8'd0 : port;
    fresh_eff = in_start || fresh;
    active    = in_start || (pos < len);
    pos_next  = p + 8'd1;
    is_hdr    = (p >= 8'd1 && p <= 8'd7) || ({1'b0, p} == {5'd0, opt_next} + 9'd8);
    in_pay    = !is_hdr && ({1'b0, p} >= {1'b0, HDR_FIXED} + {5'd0, opt_next})
                && ({2'b0, p} + {2'b0, MIC_BYTES} < {2'b0, len_next});
    last      = ({1'b0, p} + 9'd1) >= {1'b0, len_next};
    off       = p - HDR_FIXED - {4'd0, opt_next};
    plen      = len_next - HDR_WITH_MIC - {4'd0, opt_next};
    case (p)
      8'd1: addr_next[7:0]   = in_byte;
      8'd2: addr_next[15:8]  = in_byte;
      8'd3: addr_next[23:16] = in_byte;
      8'd4: addr_next[31:24] = in_byte;
      8'd5: opt_next         = 4'(in_byte & OPT_MASK);
      8'd6: fcnt_next[7:0]   = in_byte;
      8'd7: fcnt_next[15:8]  = in_byte;
      default: begin
        if ({1'b0, p} == {5'd0, opt_next} + 9'd8) port_next = in_byte;
      end
    endcase
    push = accept && active && (in_pay || last);
    entry.kind       = in_pay ? KIND_PAYLOAD : KIND_SUMMARY;
    entry.fresh      = fresh_eff;
    entry.blk_start  = off[3:0] == 4'd0;
    entry.final_part = (plen[3:0] != 4'd0) && (off[7:4] == plen[7:4]);
    entry.idx        = off[3:0];
    entry.blk_count  = {4'd0, off[7:4]} + 8'd1;
    entry.data       = in_byte;
    entry.addr       = addr_next;
    entry.fcnt       = fcnt_next;
    entry.port       = port_next;
    entry.status     = {1'b0, len_next} < ({1'b0, HDR_WITH_MIC} + {5'd0, opt_next});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= '0;
      len   <= '0;
      addr  <= '0;
      fcnt  <= '0;
      opt   <= '0;
      port  <= '0;
      fresh <= 1'b0;
    end else if (accept && active) begin
      pos   <= pos_next;
      len   <= len_next;
      addr  <= addr_next;
      fcnt  <= fcnt_next;
      opt   <= opt_next;
      port  <= port_next;
      fresh <= fresh_eff && !push;
    end
  end

endmodule
`default_nettype wire

/* src/lpd_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none
module lpd_fifo (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire lpd_pkg::lpd_entry_t  wr_entry,
  output logic                      full,
  input  wire logic                 pop,
  output logic                      head_valid,
  output lpd_pkg::lpd_entry_t       head
);
  import lpd_pkg::*;

  lpd_entry_t        slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_pop;

  assign full       = count == (QPTR_W + 1)'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head       = slots[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wr_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (QPTR_W + 1)'(push) - (QPTR_W + 1)'(do_pop);
    end
  end

endmodule
`default_nettype wire

/* src/lpd_aes.sv */
`timescale 1ns / 1ps
`default_nettype none
module lpd_aes (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire lpd_pkg::blk_t key,
  input  wire lpd_pkg::blk_t blk,
  output logic               done,
  output lpd_pkg::blk_t      result
);
  import lpd_pkg::*;

  blk_t             state, rk, nk;
  logic [7:0]       rcon;
  logic [RND_W-1:0] rnd;
  logic             busy;

  assign nk     = next_key(rk, rcon);
  assign result = state;

  always_ff @(posedge clk) begin
    if (start) begin
      state <= blk ^ key;
      rk    <= key;
      rcon  <= RCON_FIRST;
    end else if (busy) begin
      state <= aes_round(state, nk, rnd == RND_W'(AES_ROUNDS));
      rk    <= nk;
      rcon  <= xtime(rcon);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      rnd  <= '0;
      done <= 1'b0;
    end else begin
      done <= busy && rnd == RND_W'(AES_ROUNDS);
      if (start) begin
        busy <= 1'b1;
        rnd  <= RND_W'(1);
      end else if (busy) begin
        if (rnd == RND_W'(AES_ROUNDS)) busy <= 1'b0;
        rnd <= rnd + 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

/* src/lpd_back.sv */
`timescale 1ns / 1ps
`default_nettype none
module lpd_back (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire lpd_pkg::lpd_keys_t   keys,
  input  wire logic                 head_valid,
  input  wire lpd_pkg::lpd_entry_t  head,
  output logic                      pop,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      out_kind,
  output logic [7:0]                out_plain,
  output logic [31:0]               out_addr,
  output logic [15:0]               out_fcnt,
  output logic [7:0]                out_port,
  output logic [7:0]                out_count,
  output logic                      out_status
);
  import lpd_pkg::*;

  back_state_t state, state_next;
  blk_t        ks, aes_key, aes_blk, aes_result;
  logic        aes_start, aes_done, needs_ks, advance;
  logic [7:0]  emitted, em_base, plain;
  logic        stopped, st_base, emit;

  assign needs_ks = head.kind == KIND_PAYLOAD && head.blk_start;
  assign advance  = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE:   if (head_valid && needs_ks) state_next = BK_CRYPT;
      BK_CRYPT:  if (aes_done) state_next = BK_LOADED;
      BK_LOADED: if (advance) state_next = BK_IDLE;
      default:   state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    aes_start = 1'b0;
    pop       = 1'b0;
    case (state)
      BK_IDLE: begin
        aes_start = head_valid && needs_ks;
        pop       = advance && head_valid && !needs_ks;
      end
      BK_LOADED: pop = advance && head_valid;
      default: begin
        aes_start = 1'b0;
        pop       = 1'b0;
      end
    endcase
  end

  always_comb begin
    aes_key     = (head.port == 8'd0) ? keys.net_key : keys.app_key;
    aes_blk     = '0;
    aes_blk[0]  = ABLK_TAG;
    aes_blk[5]  = {7'd0, keys.dir};
    aes_blk[6]  = head.addr[7:0];
    aes_blk[7]  = head.addr[15:8];
    aes_blk[8]  = head.addr[23:16];
    aes_blk[9]  = head.addr[31:24];
    aes_blk[10] = head.fcnt[7:0];
    aes_blk[11] = head.fcnt[15:8];
    aes_blk[15] = head.blk_count;
  end

  lpd_aes u_aes (
    .clk    (clk),
    .rst    (rst),
    .start  (aes_start),
    .key    (aes_key),
    .blk    (aes_blk),
    .done   (aes_done),
    .result (aes_result)
  );

  always_comb begin
    em_base = head.fresh ? 8'd0 : emitted;
    st_base = head.fresh ? 1'b0 : stopped;
    plain   = head.data ^ ks[head.idx];
    emit    = head.kind == KIND_SUMMARY
              || (!st_base && !(head.final_part && plain == 8'd0));
  end

  always_ff @(posedge clk) begin
    if (aes_done) ks <= aes_result;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      out_valid <= 1'b0;
      emitted   <= '0;
      stopped   <= 1'b0;
    end else begin
      state <= state_next;
      if (advance) out_valid <= pop && emit;
      if (pop) begin
        if (head.kind == KIND_PAYLOAD) begin
          emitted <= em_base + 8'(emit);
          stopped <= !emit;
        end else begin
          emitted <= em_base;
          stopped <= st_base;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_kind <= head.kind;
      if (head.kind == KIND_PAYLOAD) begin
        out_plain  <= plain;
        out_addr   <= '0;
        out_fcnt   <= '0;
        out_port   <= '0;
        out_count  <= '0;
        out_status <= 1'b0;
      end else begin
        out_plain  <= '0;
        out_addr   <= head.addr;
        out_fcnt   <= head.fcnt;
        out_port   <= head.port;
        out_count  <= em_base;
        out_status <= head.status;
      end
    end
  end

endmodule
`default_nettype wire

/* tb/sv/lorawan_payload_decrypt_top_tb.sv */
`timescale 1ns / 1ps
module lorawan_payload_decrypt_top_tb;
  import lpd_pkg::*;

  localparam int CYCLE_LIMIT = 1500000;
  localparam int HOLD_FROM = 3000;
  localparam int HOLD_CYCLES = 900;
  localparam int SETTLE_CYCLES = 80;

  typedef struct packed {
    logic        kind;
    logic [7:0]  plain;
    logic [31:0] addr;
    logic [15:0] fcnt;
    logic [7:0]  port;
    logic [7:0]  count;
    logic        status;
  } record_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [15:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [79:0] m_tdata;
  logic m_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  logic [16:0] pending_bytes[$];
  record_t expected_records[$];
  int errors = 0;
  int cyc = 0;

  logic [127:0] app_key = '0, net_key = '0;
  logic link_dir = 1'b0;

  logic [7:0] fr_pos, fr_len, fr_port, fr_blk, fr_emit;
  logic [31:0] fr_addr;
  logic [15:0] fr_cnt;
  logic [3:0] fr_opts;
  logic [7:0] keystream[16];
  logic fr_stop;

  lorawan_payload_decrypt_top DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic logic [7:0] gf_double(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [127:0] aes_encrypt(input logic [127:0] key, input logic [127:0] blk);
    logic [7:0] w[176];
    logic [7:0] s[16];
    logic [7:0] t[16];
    logic [7:0] a, b, d, e, tmp, rc, all, a0, a1, a2, a3;
    logic [127:0] res;
    int i, r, c;
    rc = 8'h01;
    for (i = 0; i < 16; i++) w[i] = key[127-8*i -: 8];
    for (i = 16; i < 176; i += 4) begin
      a = w[i-4]; b = w[i-3]; d = w[i-2]; e = w[i-1];
      if ((i & 15) == 0) begin
        tmp = a;
        a = SBOX[b] ^ rc;
        b = SBOX[d];
        d = SBOX[e];
        e = SBOX[tmp];
        rc = gf_double(rc);
      end
      w[i] = w[i-16] ^ a;
      w[i+1] = w[i-15] ^ b;
      w[i+2] = w[i-14] ^ d;
      w[i+3] = w[i-13] ^ e;
    end
    for (i = 0; i < 16; i++) s[i] = blk[127-8*i -: 8] ^ w[i];
    for (r = 1; r <= 10; r++) begin
      for (i = 0; i < 16; i++) t[i] = SBOX[s[(i & 3) + 4 * (((i >> 2) + (i & 3)) & 3)]];
      if (r < 10) begin
        for (c = 0; c < 4; c++) begin
          a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
          all = a0 ^ a1 ^ a2 ^ a3;
          t[4*c] = a0 ^ all ^ gf_double(a0 ^ a1);
          t[4*c+1] = a1 ^ all ^ gf_double(a1 ^ a2);
          t[4*c+2] = a2 ^ all ^ gf_double(a2 ^ a3);
          t[4*c+3] = a3 ^ all ^ gf_double(a3 ^ a0);
        end
      end
      for (i = 0; i < 16; i++) s[i] = t[i] ^ w[16*r+i];
    end
    for (i = 0; i < 16; i++) res[127-8*i -: 8] = s[i];
    return res;
  endfunction

  task automatic refill_keystream();
    logic [127:0] ablk, ks;
    int i;
    ablk = {8'h01, 32'h0, 7'h0, link_dir, fr_addr[7:0], fr_addr[15:8], fr_addr[23:16],
            fr_addr[31:24], fr_cnt[7:0], fr_cnt[15:8], 16'h0, 8'h00, fr_blk};
    ks = aes_encrypt((fr_port == 8'd0) ? net_key : app_key, ablk);
    for (i = 0; i < 16; i++) keystream[i] = ks[127-8*i -: 8];
    fr_blk = fr_blk + 8'd1;
  endtask

  task automatic decrypt_byte(input logic [7:0] b, input logic st, input logic [7:0] ln);
    int p, pstart, pend, off, plen;
    logic last, final_part;
    logic [7:0] pl;
    record_t rec;
    if (st) begin
      fr_len = ln; fr_pos = '0; fr_addr = '0; fr_cnt = '0; fr_opts = '0; fr_port = '0;
      fr_blk = 8'd1; fr_emit = '0; fr_stop = 1'b0;
    end else if (fr_pos >= fr_len) begin
      return;
    end
    p = int'(fr_pos);
    pstart = 9 + int'(fr_opts);
    pend = int'(fr_len) - 4;
    last = (p + 1 >= int'(fr_len));
    fr_pos = 8'(p + 1);
    rec = '0;
    if (p >= 1 && p <= 4) begin
      fr_addr = fr_addr | (32'(b) << (8 * (p - 1)));
    end else if (p == 5) begin
      fr_opts = b[3:0];
    end else if (p == 6) begin
      fr_cnt[7:0] = b;
    end else if (p == 7) begin
      fr_cnt[15:8] = b;
    end else if (p == 8 + int'(fr_opts)) begin
      fr_port = b;
    end else if (p >= pstart && p < pend) begin
      off = p - pstart;
      plen = pend - pstart;
      if ((off & 15) == 0) refill_keystream();
      pl = b ^ keystream[off & 15];
      final_part = ((plen & 15) != 0) && ((off >> 4) == (plen >> 4));
      if (fr_stop) return;
      if (final_part && pl == 8'd0) begin
        fr_stop = 1'b1;
        return;
      end
      fr_emit = fr_emit + 8'd1;
      rec.kind = KIND_PAYLOAD;
      rec.plain = pl;
      expected_records.push_back(rec);
      return;
    end
    if (last) begin
      rec.kind = KIND_SUMMARY;
      rec.addr = fr_addr;
      rec.fcnt = fr_cnt;
      rec.port = fr_port;
      rec.count = fr_emit;
      rec.status = (int'(fr_len) < 13 + int'(fr_opts));
      expected_records.push_back(rec);
    end
  endtask

  task automatic queue_byte(input logic [7:0] b, input logic st, input logic [7:0] ln);
    decrypt_byte(b, st, ln);
    pending_bytes.push_back({st, ln, b});
  endtask

  // zero_odds: 1 in zero_odds chance to force a zero plaintext byte in a final block
  task automatic queue_frame(input int len, input int fopts, input logic [7:0] port,
                             input int sent, input int zero_odds);
    logic [7:0] b;
    int i, off, plen, ps, pe;
    for (i = 0; i < sent; i++) begin
      b = 8'($urandom_range(0, 255));
      if (i == 5) b = {b[7:4], 4'(fopts)};
      if (i == 8 + fopts) b = port;
      ps = 9 + int'(fr_opts);
      pe = int'(fr_len) - 4;
      if (i > 0 && zero_odds > 0 && i >= ps && i < pe) begin
        off = i - ps;
        plen = pe - ps;
        if ((off & 15) != 0 && (plen & 15) != 0 && (off >> 4) == (plen >> 4) &&
            $urandom_range(1, zero_odds) == 1)
          b = keystream[off & 15];
      end
      queue_byte(b, i == 0, 8'(len));
    end
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [63:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_APP_KEY_HIGH: app_key[127:64] = val;
      CFG_APP_KEY_LOW: app_key[63:0] = val;
      CFG_NET_KEY_HIGH: net_key[127:64] = val;
      CFG_NET_KEY_LOW: net_key[63:0] = val;
      CFG_LINK_DIRECTION: link_dir = val[0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (pending_bytes.size() != 0 || s_tvalid || expected_records.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        s_tvalid <= 1'b0;
      end else if (pending_bytes.size() != 0) begin
        {s_tuser, s_tdata} <= pending_bytes.pop_front();
        s_tvalid <= 1'b1;
        if (burst_left <= 0) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  int stall_mode = 0;

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc >= CYCLE_LIMIT) begin
      $display("FAIL lorawan_payload_decrypt_top");
      $finish;
    end
    if (cyc % 64 == 0) stall_mode <= $urandom_range(0, 3);
    if (cyc >= HOLD_FROM && cyc < HOLD_FROM + HOLD_CYCLES)
      m_tready <= 1'b0;
    else
      case (stall_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= 1'($urandom_range(0, 1));
        2: m_tready <= ($urandom_range(0, 3) == 0);
        default: m_tready <= ($urandom_range(0, 7) != 0);
      endcase
  end

  always @(posedge clk) begin
    record_t want, got;
    if (!rst && m_tvalid && m_tready) begin
      got = '{kind: m_tuser, plain: m_tdata[7:0], addr: m_tdata[39:8],
              fcnt: m_tdata[55:40], port: m_tdata[63:56], count: m_tdata[71:64],
              status: m_tdata[72]};
      if (expected_records.size() == 0) begin
        $display("%0t: unexpected beat kind=%0d data=%h", $time, m_tuser, m_tdata);
        errors++;
      end else begin
        want = expected_records.pop_front();
        if (got.kind !== want.kind) begin
          $display("%0t: kind exp %0d got %0d", $time, want.kind, got.kind); errors++;
        end
        if (got.plain !== want.plain) begin
          $display("%0t: plain exp %h got %h", $time, want.plain, got.plain); errors++;
        end
        if (got.addr !== want.addr) begin
          $display("%0t: addr exp %h got %h", $time, want.addr, got.addr); errors++;
        end
        if (got.fcnt !== want.fcnt) begin
          $display("%0t: fcnt exp %h got %h", $time, want.fcnt, got.fcnt); errors++;
        end
        if (got.port !== want.port) begin
          $display("%0t: port exp %h got %h", $time, want.port, got.port); errors++;
        end
        if (got.count !== want.count) begin
          $display("%0t: count exp %0d got %0d", $time, want.count, got.count); errors++;
        end
        if (got.status !== want.status) begin
          $display("%0t: status exp %0d got %0d", $time, want.status, got.status); errors++;
        end
      end
    end
  end

  initial begin
    int ph, sent, r, fopts, len, cut, i;
    logic [7:0] port;
    fr_pos = '0; fr_len = '0; fr_addr = '0; fr_cnt = '0; fr_opts = '0; fr_port = '0;
    fr_blk = 8'd1; fr_emit = '0; fr_stop = 1'b0;
    for (i = 0; i < 16; i++) keystream[i] = 8'h00;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (ph = 0; ph < 6; ph++) begin
      wait_idle();
      case (ph)
        0: begin
          write_reg(CFG_APP_KEY_HIGH, '0); write_reg(CFG_APP_KEY_LOW, '0);
          write_reg(CFG_NET_KEY_HIGH, '0); write_reg(CFG_NET_KEY_LOW, '0);
          write_reg(CFG_LINK_DIRECTION, 64'd0);
        end
        1: begin
          write_reg(CFG_APP_KEY_HIGH, '1); write_reg(CFG_APP_KEY_LOW, '1);
          write_reg(CFG_NET_KEY_HIGH, '1); write_reg(CFG_NET_KEY_LOW, '1);
          write_reg(CFG_LINK_DIRECTION, 64'd1);
        end
        default: begin
          write_reg(CFG_APP_KEY_HIGH, {$urandom, $urandom});
          write_reg(CFG_APP_KEY_LOW, {$urandom, $urandom});
          write_reg(CFG_NET_KEY_HIGH, {$urandom, $urandom});
          write_reg(CFG_NET_KEY_LOW, {$urandom, $urandom});
          write_reg(CFG_LINK_DIRECTION, {$urandom, $urandom});
        end
      endcase

      if (ph == 0) begin
        queue_byte(8'h00, 1'b0, 8'h00);
        queue_frame(0, 0, 8'h00, 1, 0);
        queue_frame(1, 0, 8'h00, 1, 0);
        queue_byte(8'hff, 1'b0, 8'hff);
        queue_frame(6, 0, 8'h01, 6, 0);
        queue_frame(20, 2, 8'h05, 9, 0);
        queue_byte(8'hff, 1'b1, 8'd13);
        for (i = 1; i < 13; i++) queue_byte((i == 5) ? 8'hf0 : 8'hff, 1'b0, 8'd13);
        queue_frame(32, 0, 8'h00, 32, 2);
      end

      sent = 0;
      while (sent < 270) begin
        r = $urandom_range(0, 99);
        fopts = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 15);
        port = ($urandom_range(0, 4) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
        if (r < 5) begin
          for (i = 0; i < $urandom_range(1, 3); i++)
            queue_byte(8'($urandom), 1'b0, 8'($urandom));
          continue;
        end else if (r < 12) begin
          len = $urandom_range(0, 12 + fopts);
          cut = (len == 0) ? 1 : len;
        end else if (r < 18) begin
          len = $urandom_range(13 + fopts, 80);
          cut = $urandom_range(1, len - 1);
        end else if (r < 21) begin
          len = $urandom_range(13 + fopts, 255);
          cut = len;
        end else begin
          len = 13 + fopts + $urandom_range(0, 40);
          cut = len;
        end
        queue_frame(len, fopts, port, cut, 4);
        sent += cut;
      end
    end

    wait_idle();
    if (expected_records.size() != 0)
      $display("%0t: %0d expected beats never arrived", $time, expected_records.size());
    if (errors == 0 && expected_records.size() == 0) begin
      $display("PASS lorawan_payload_decrypt_top");
    end else begin
      $display("FAIL lorawan_payload_decrypt_top");
    end
    $finish;
  end

endmodule
